// ===== hw/rtl/sound_level_bar_with_peak_hold_core_assert.svh =====
// ----------------------------------------------------------------------------
// Sound level bar assertion macros
// Shorthand for clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_BAR_WITH_PEAK_HOLD_CORE_ASSERT_SVH
`define SOUND_LEVEL_BAR_WITH_PEAK_HOLD_CORE_ASSERT_SVH

// same-cycle implication
`define SLB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slb check failed");

// next-cycle implication
`define SLB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slb check failed");

`endif

// ===== hw/rtl/slb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound level bar package
// Widths, constants, sequencer states and scaling helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package slb_pkg;

  localparam int WINDOW      = 512;
  localparam int LED_COUNT   = 144;

  localparam int SAMPLE_W    = 16;
  localparam int LVL_W       = 11;
  localparam int LEVEL_SHIFT = 4;
  localparam int LEVEL_MAX   = 1024;
  localparam int SCALE_SHIFT = 10;
  localparam int GROUP_LEN   = 7;
  localparam int GRP_W       = 3;

  localparam int RING_AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int LED_W       = $clog2(LED_COUNT + 1);
  localparam int PROD_W      = LVL_W + LED_W;
  localparam int SHIFTED_W   = SAMPLE_W - LEVEL_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BAR,
    ST_PEAK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             push;
    logic [LVL_W-1:0] data;
  } ring_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] peak;
  } ring_stat_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [SAMPLE_W-1:0] sample);
    logic [SHIFTED_W-1:0] s;
    s = SHIFTED_W'(sample >> LEVEL_SHIFT);
    if (s > SHIFTED_W'(LEVEL_MAX)) begin
      return LVL_W'(LEVEL_MAX);
    end
    return LVL_W'(s);
  endfunction

  function automatic logic [LVL_W-1:0] scale_to_leds(input logic [LVL_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(LED_COUNT);
    return LVL_W'(prod >> SCALE_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/slb_if.sv =====
// ----------------------------------------------------------------------------
// Sound level bar channels
// Valid/ready channels for input samples and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface slb_in_if;
  logic                          valid;
  logic                          ready;
  logic [slb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface slb_out_if;
  logic                       valid;
  logic                       ready;
  logic [slb_pkg::LVL_W-1:0]  level;
  logic [slb_pkg::LVL_W-1:0]  bar_length;
  logic [slb_pkg::LVL_W-1:0]  peak_length;

  modport source (output valid, output level, output bar_length, output peak_length,
                  input ready);
  modport sink   (input valid, input level, input bar_length, input peak_length,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slb_ring.sv =====
// ----------------------------------------------------------------------------
// Sound level bar peak ring
// Ring of group peaks with a one-entry-per-cycle maximum scan after each push.
// ----------------------------------------------------------------------------
`default_nettype none

module slb_ring (
  input  wire                  clk,
  input  wire                  rst,
  input  slb_pkg::ring_req_t   req,
  output slb_pkg::ring_stat_t  stat
);

  logic [slb_pkg::LVL_W-1:0]   mem [slb_pkg::WINDOW];
  logic [slb_pkg::LVL_W-1:0]   rdata;
  logic [slb_pkg::RING_AW-1:0] wr_pos;
  logic [slb_pkg::FILL_W-1:0]  fill;
  logic [slb_pkg::FILL_W-1:0]  scan_idx;
  logic [slb_pkg::LVL_W-1:0]   scan_max;
  logic                        scanning;
  logic                        rd_pend;
  logic                        done;
  logic                        rd_en;

  assign rd_en = scanning && (scan_idx != fill);

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_pos] <= req.data;
    end
    if (rd_en) begin
      rdata <= mem[scan_idx[slb_pkg::RING_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos   <= '0;
      fill     <= '0;
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.push) begin
        if (wr_pos == slb_pkg::RING_AW'(slb_pkg::WINDOW - 1)) begin
          wr_pos <= '0;
        end else begin
          wr_pos <= wr_pos + 1'b1;
        end
        if (fill != slb_pkg::FILL_W'(slb_pkg::WINDOW)) begin
          fill <= fill + 1'b1;
        end
        scanning <= 1'b1;
        rd_pend  <= 1'b0;
      end else if (scanning) begin
        rd_pend <= rd_en;
        if (!rd_en && !rd_pend) begin
          scanning <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  // scan datapath: one compare per cycle
  always_ff @(posedge clk) begin
    if (req.push) begin
      scan_idx <= '0;
      scan_max <= '0;
    end else if (scanning) begin
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_pend && (rdata > scan_max)) begin
        scan_max <= rdata;
      end
    end
  end

  assign stat.done = done;
  assign stat.peak = scan_max;

endmodule

`default_nettype wire

// ===== hw/rtl/sound_level_bar_with_peak_hold_core.sv =====
// ----------------------------------------------------------------------------
// Sound level bar with peak hold
// Level, bar length and sliding-window peak-hold length per sample.
// ----------------------------------------------------------------------------
// din carries one 16-bit converter sample per word; dout returns one word
// per sample: level (sample >> 4, clamped to 1024), bar_length and
// peak_length, both scaled as floor(x * LED_COUNT / 1024).
// Samples are taken one at a time; din.ready is high only in idle.
// Six of every seven samples pass from idle through BAR, PEAK and DONE, where
// the result word is loaded into dout, before the next sample can be accepted.
// The seventh closes a group: its peak is pushed into the ring and the ring
// is rescanned one entry per cycle through its single read port in the SCAN
// state before BAR, so its word waits on a scan of up to WINDOW (512) entries.
// One shared multiplier computes bar and peak lengths in turn.
// dout is a register: a new sample is accepted while a word waits, and the
// next word is held back until dout.ready frees the register.
// Reset clears the group counter, group peak, ring fill and write position;
// peak_length reads zero until the first group completes.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_level_bar_with_peak_hold_core (
  input wire        clk,
  input wire        rst,
  slb_in_if.sink    din,
  slb_out_if.source dout
);

  slb_pkg::state_t               state, state_next;
  slb_pkg::ring_req_t            ring_req;
  slb_pkg::ring_stat_t           ring_stat;

  logic [slb_pkg::GRP_W-1:0]     group_count;
  logic [slb_pkg::LVL_W-1:0]     group_peak;
  logic [slb_pkg::LVL_W-1:0]     level_q;
  logic [slb_pkg::LVL_W-1:0]     hold_max;
  logic [slb_pkg::LVL_W-1:0]     bar_q;
  logic [slb_pkg::LVL_W-1:0]     peak_q;
  logic [slb_pkg::LVL_W-1:0]     lvl_in;
  logic [slb_pkg::LVL_W-1:0]     gp_in;
  logic [slb_pkg::LVL_W-1:0]     mul_a;
  logic [slb_pkg::LVL_W-1:0]     mul_out;
  logic                          accept;
  logic                          group_end;
  logic                          load_out;
  logic                          out_valid;

  slb_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .req  (ring_req),
    .stat (ring_stat)
  );

  assign lvl_in    = slb_pkg::clamp_level(din.sample);
  assign gp_in     = (lvl_in > group_peak) ? lvl_in : group_peak;
  assign group_end = (group_count == slb_pkg::GRP_W'(slb_pkg::GROUP_LEN - 1));

  assign ring_req.push = accept && group_end;
  assign ring_req.data = gp_in;

  // shared scaling multiplier
  assign mul_a   = (state == slb_pkg::ST_PEAK) ? hold_max : level_q;
  assign mul_out = slb_pkg::scale_to_leds(mul_a);

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    load_out   = 1'b0;
    din.ready  = 1'b0;
    case (state)
      slb_pkg::ST_IDLE: begin
        din.ready = 1'b1;
        if (din.valid) begin
          accept     = 1'b1;
          state_next = group_end ? slb_pkg::ST_SCAN : slb_pkg::ST_BAR;
        end
      end
      slb_pkg::ST_SCAN: begin
        if (ring_stat.done) begin
          state_next = slb_pkg::ST_BAR;
        end
      end
      slb_pkg::ST_BAR: begin
        state_next = slb_pkg::ST_PEAK;
      end
      slb_pkg::ST_PEAK: begin
        state_next = slb_pkg::ST_DONE;
      end
      slb_pkg::ST_DONE: begin
        if (!out_valid || dout.ready) begin
          load_out   = 1'b1;
          state_next = slb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= slb_pkg::ST_IDLE;
      group_count <= '0;
      group_peak  <= '0;
      hold_max    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (group_end) begin
          group_count <= '0;
          group_peak  <= '0;
        end else begin
          group_count <= group_count + 1'b1;
          group_peak  <= gp_in;
        end
      end
      if (state == slb_pkg::ST_SCAN && ring_stat.done) begin
        hold_max <= ring_stat.peak;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      level_q <= lvl_in;
    end
    if (state == slb_pkg::ST_BAR) begin
      bar_q <= mul_out;
    end
    if (state == slb_pkg::ST_PEAK) begin
      peak_q <= mul_out;
    end
    if (load_out) begin
      dout.level       <= level_q;
      dout.bar_length  <= bar_q;
      dout.peak_length <= peak_q;
    end
  end

  assign dout.valid = out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/slb_check.sv =====
// ----------------------------------------------------------------------------
// Sound level bar port checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sound_level_bar_with_peak_hold_core_assert.svh"

module slb_check (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [slb_pkg::LVL_W-1:0]   level,
  input wire [slb_pkg::LVL_W-1:0]   bar_length,
  input wire [slb_pkg::LVL_W-1:0]   peak_length
);

  `SLB_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `SLB_ASSERT_IMP(a_level_range, clk, rst, out_valid,
                  level <= slb_pkg::LVL_W'(slb_pkg::LEVEL_MAX))
  `SLB_ASSERT_IMP(a_bar_range, clk, rst, out_valid,
                  bar_length <= slb_pkg::LVL_W'(slb_pkg::LED_COUNT))
  `SLB_ASSERT_IMP(a_peak_range, clk, rst, out_valid,
                  peak_length <= slb_pkg::LVL_W'(slb_pkg::LED_COUNT))
  `SLB_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(level) && $stable(peak_length))

endmodule

bind sound_level_bar_with_peak_hold_core slb_check u_slb_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .level       (dout.level),
  .bar_length  (dout.bar_length),
  .peak_length (dout.peak_length)
);

`default_nettype wire
